@@ design/ksps_pkg.sv @@
`timescale 1ns / 1ps
package ksps_pkg;
    localparam int unsigned VALUE_W    = 30;
    localparam int unsigned SUM_W      = 31;
    localparam int unsigned RANK_W     = 21;
    localparam int unsigned DEF_MAX_ELEMENTS = 1024;
    localparam logic [SUM_W-1:0] SUM_LIMIT = 31'd2000000000;

    // controller to datapath
    typedef struct packed {
        logic load;        // write beat into stores
        logic cnt_clr;     // element count back to zero
        logic snap;        // latch n, check rank
        logic sort_start;
        logic srch_init;   // lo/hi of outer search
        logic round_start; // start one pair count at mid (or limit)
        logic use_limit;
        logic round_done_take; // apply round outcome to lo/hi
        logic res_load;
        logic res_ok;
    } ksps_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic rank_ok;
        logic sort_busy;
        logic round_busy;
        logic round_ge;    // count >= k
        logic srch_done;   // lo >= hi
    } ksps_sts_t;
endpackage

@@ design/ksps_ram.sv @@
`timescale 1ns / 1ps
module ksps_ram #(
    parameter int unsigned WIDTH = 30,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ design/ksps_datapath.sv @@
`timescale 1ns / 1ps
module ksps_datapath #(
    parameter int unsigned MAX_ELEMENTS = ksps_pkg::DEF_MAX_ELEMENTS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ksps_pkg::ksps_cmd_t          cmd,
    output ksps_pkg::ksps_sts_t          sts,
    input  logic [ksps_pkg::VALUE_W-1:0] value_a,
    input  logic [ksps_pkg::VALUE_W-1:0] value_b,
    input  logic [ksps_pkg::RANK_W-1:0]  k_rank,
    output logic [ksps_pkg::SUM_W-1:0]   res_sum,
    output logic                         res_found
);
    import ksps_pkg::*;

    localparam int unsigned AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);
    localparam int unsigned PW = 2 * CW;
    localparam int unsigned MW = (PW > RANK_W) ? PW : RANK_W;
    localparam int unsigned RD = 1 << AW;

    // element count
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] n_reg;
    logic          full;
    assign full = (cnt_reg == CW'(MAX_ELEMENTS));

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.cnt_clr)
        begin
            cnt_next = '0;
        end
        else if (cmd.load && !full)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // rank check: n*n >= k
    logic [PW-1:0] nsq;
    logic          rank_ok_reg;
    assign nsq = PW'(cnt_reg) * PW'(cnt_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.snap)
        begin
            n_reg       <= cnt_reg;
            rank_ok_reg <= (MW'(nsq) >= MW'(k_rank));
        end
    end
    assign sts.rank_ok = rank_ok_reg;

    // memories: a and b, shared by load, sort and search
    logic            a_we, b_we;
    logic [AW-1:0]   a_wa, b_wa, a_ra, b_ra;
    logic [VALUE_W-1:0] a_wd, b_wd, a_rd, b_rd;

    ksps_ram #(.WIDTH(VALUE_W), .DEPTH(RD)) u_ram_a (
        .clk(clk), .we(a_we), .waddr(a_wa), .wdata(a_wd), .raddr(a_ra), .rdata(a_rd));
    ksps_ram #(.WIDTH(VALUE_W), .DEPTH(RD)) u_ram_b (
        .clk(clk), .we(b_we), .waddr(b_wa), .wdata(b_wd), .raddr(b_ra), .rdata(b_rd));

    // insertion sort, a then b in turn through the same lanes; sel 0=a, 1=b
    // states: idle, read key, read prev, compare/shift, place
    localparam logic [2:0] S_IDLE = 3'd0, S_KEY = 3'd1, S_KEYW = 3'd2,
                           S_PRV = 3'd3, S_CMP = 3'd4;
    logic [2:0]         ss_reg, ss_next;
    logic               sel_reg, sel_next;
    logic [CW-1:0]      si_reg, si_next, sj_reg, sj_next;
    logic [VALUE_W-1:0] key_reg, key_next;
    logic               sw_en;
    logic [AW-1:0]      sw_a, sr_a;
    logic [VALUE_W-1:0] sw_d, s_rd;

    assign s_rd = sel_reg ? b_rd : a_rd;

    always_comb
    begin
        ss_next  = ss_reg;
        sel_next = sel_reg;
        si_next  = si_reg;
        sj_next  = sj_reg;
        key_next = key_reg;
        sw_en    = 1'b0;
        sw_a     = sj_reg[AW-1:0];
        sw_d     = key_reg;
        sr_a     = si_reg[AW-1:0];
        unique case (ss_reg)
            S_IDLE:
            begin
                if (cmd.sort_start)
                begin
                    sel_next = 1'b0;
                    si_next  = CW'(1);
                    ss_next  = S_KEY;
                end
            end
            S_KEY:
            begin
                if (si_reg >= n_reg)
                begin
                    if (sel_reg)
                    begin
                        ss_next = S_IDLE;
                    end
                    else
                    begin
                        sel_next = 1'b1;
                        si_next  = CW'(1);
                    end
                end
                else
                begin
                    sr_a    = si_reg[AW-1:0];
                    sj_next = si_reg;
                    ss_next = S_KEYW;
                end
            end
            S_KEYW:
            begin
                key_next = s_rd;
                sr_a     = AW'(sj_reg - 1'b1);
                ss_next  = S_PRV;
            end
            S_PRV:
            begin
                // s_rd = v[j-1]
                if (s_rd > key_reg)
                begin
                    sw_en   = 1'b1;
                    sw_a    = sj_reg[AW-1:0];
                    sw_d    = s_rd;
                    sj_next = sj_reg - 1'b1;
                    if (sj_reg == CW'(1))
                    begin
                        ss_next = S_CMP;
                    end
                    else
                    begin
                        sr_a = AW'(sj_reg - 2'd2);
                    end
                end
                else
                begin
                    ss_next = S_CMP;
                end
            end
            S_CMP:
            begin
                sw_en   = 1'b1;
                sw_a    = sj_reg[AW-1:0];
                sw_d    = key_reg;
                si_next = si_reg + 1'b1;
                ss_next = S_KEY;
            end
            default: ss_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ss_reg <= S_IDLE;
        end
        else
        begin
            ss_reg <= ss_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg <= sel_next;
        si_reg  <= si_next;
        sj_reg  <= sj_next;
        key_reg <= key_next;
    end

    assign sts.sort_busy = (ss_reg != S_IDLE);

    // pair count for one x: per a[i], binary search in b
    localparam logic [2:0] C_IDLE = 3'd0, C_RDA = 3'd1, C_GETA = 3'd2,
                           C_BS = 3'd3, C_BSW = 3'd4, C_ADD = 3'd5;
    logic [2:0]          cs_reg, cs_next;
    logic [SUM_W-1:0]    x_reg, x_next;
    logic [CW-1:0]       ci_reg, ci_next, blo_reg, blo_next, bhi_reg, bhi_next;
    logic [SUM_W-1:0]    lim_reg, lim_next;
    logic [PW-1:0]       tot_reg, tot_next;
    logic [CW-1:0]       bmid;
    logic [AW-1:0]       cra, crb;
    logic [SUM_W-1:0]    mid;
    logic [SUM_W-1:0]    olo_reg, olo_next, ohi_reg, ohi_next;

    assign bmid = blo_reg + ((bhi_reg - blo_reg) >> 1);
    assign mid  = olo_reg + ((ohi_reg - olo_reg) >> 1);

    always_comb
    begin
        cs_next  = cs_reg;
        x_next   = x_reg;
        ci_next  = ci_reg;
        blo_next = blo_reg;
        bhi_next = bhi_reg;
        lim_next = lim_reg;
        tot_next = tot_reg;
        cra      = ci_reg[AW-1:0];
        crb      = bmid[AW-1:0];
        unique case (cs_reg)
            C_IDLE:
            begin
                if (cmd.round_start)
                begin
                    x_next   = cmd.use_limit ? SUM_LIMIT : mid;
                    ci_next  = '0;
                    tot_next = '0;
                    cs_next  = C_RDA;
                end
            end
            C_RDA:
            begin
                if (ci_reg >= n_reg)
                begin
                    cs_next = C_IDLE;
                end
                else
                begin
                    cra     = ci_reg[AW-1:0];
                    cs_next = C_GETA;
                end
            end
            C_GETA:
            begin
                blo_next = '0;
                bhi_next = n_reg;
                lim_next = x_reg - SUM_W'(a_rd);
                if (SUM_W'(a_rd) <= x_reg)
                begin
                    cs_next = C_BS;
                end
                else
                begin
                    ci_next = ci_reg + 1'b1;
                    cs_next = C_RDA;
                end
            end
            C_BS:
            begin
                if (blo_reg < bhi_reg)
                begin
                    crb     = bmid[AW-1:0];
                    cs_next = C_BSW;
                end
                else
                begin
                    cs_next = C_ADD;
                end
            end
            C_BSW:
            begin
                if (SUM_W'(b_rd) <= lim_reg)
                begin
                    blo_next = bmid + 1'b1;
                end
                else
                begin
                    bhi_next = bmid;
                end
                cs_next = C_BS;
            end
            C_ADD:
            begin
                tot_next = tot_reg + PW'(blo_reg);
                ci_next  = ci_reg + 1'b1;
                cs_next  = C_RDA;
            end
            default: cs_next = C_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cs_reg <= C_IDLE;
        end
        else
        begin
            cs_reg <= cs_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        ci_reg  <= ci_next;
        blo_reg <= blo_next;
        bhi_reg <= bhi_next;
        lim_reg <= lim_next;
        tot_reg <= tot_next;
    end

    assign sts.round_busy = (cs_reg != C_IDLE);
    assign sts.round_ge   = (MW'(tot_reg) >= MW'(k_rank));

    // outer search over sum range
    always_comb
    begin
        olo_next = olo_reg;
        ohi_next = ohi_reg;
        if (cmd.srch_init)
        begin
            olo_next = '0;
            ohi_next = SUM_LIMIT;
        end
        else if (cmd.round_done_take)
        begin
            if (sts.round_ge)
            begin
                ohi_next = x_reg;
            end
            else
            begin
                olo_next = x_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        olo_reg <= olo_next;
        ohi_reg <= ohi_next;
    end

    assign sts.srch_done = (olo_reg >= ohi_reg);

    // memory port steering
    always_comb
    begin
        a_we = 1'b0;
        b_we = 1'b0;
        a_wa = cnt_reg[AW-1:0];
        b_wa = cnt_reg[AW-1:0];
        a_wd = value_a;
        b_wd = value_b;
        a_ra = cra;
        b_ra = crb;
        if (cmd.load)
        begin
            a_we = !full;
            b_we = !full;
        end
        else if (sts.sort_busy)
        begin
            a_ra = sr_a;
            b_ra = sr_a;
            a_wa = sw_a;
            b_wa = sw_a;
            a_wd = sw_d;
            b_wd = sw_d;
            a_we = sw_en && !sel_reg;
            b_we = sw_en && sel_reg;
        end
    end

    // result
    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            res_sum   <= cmd.res_ok ? (cmd.use_limit ? SUM_LIMIT : olo_reg) : '0;
            res_found <= cmd.res_ok;
        end
    end
endmodule

@@ design/ksps_ctrl.sv @@
`timescale 1ns / 1ps
module ksps_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                last_item,
    output logic                out_valid,
    input  logic                out_ready,
    output ksps_pkg::ksps_cmd_t cmd,
    input  ksps_pkg::ksps_sts_t sts
);
    import ksps_pkg::*;

    localparam logic [3:0] ST_LOAD = 4'd0, ST_SNAP = 4'd1, ST_SORT0 = 4'd2,
                           ST_SORT = 4'd3, ST_FULL = 4'd5,
                           ST_SRCH = 4'd6, ST_RND = 4'd7,
                           ST_OUT = 4'd9;

    logic [3:0] st_reg, st_next;
    logic       out_valid_reg, out_valid_next;
    logic       acc;

    assign in_ready  = (st_reg == ST_LOAD) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign acc       = in_valid && in_ready;

    always_comb
    begin
        st_next        = st_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.load       = acc;
        unique case (st_reg)
            ST_LOAD:
            begin
                if (acc && last_item)
                begin
                    st_next = ST_SNAP;
                end
            end
            ST_SNAP:
            begin
                cmd.snap    = 1'b1;
                cmd.cnt_clr = 1'b1;
                st_next     = ST_SORT0;
            end
            ST_SORT0:
            begin
                if (!sts.rank_ok)
                begin
                    cmd.res_load = 1'b1;
                    st_next      = ST_OUT;
                end
                else
                begin
                    cmd.sort_start = 1'b1;
                    st_next        = ST_SORT;
                end
            end
            ST_SORT:
            begin
                if (!sts.sort_busy)
                begin
                    cmd.round_start = 1'b1;
                    cmd.use_limit   = 1'b1;
                    st_next         = ST_FULL;
                end
            end
            ST_FULL:
            begin
                if (!sts.round_busy)
                begin
                    if (sts.round_ge)
                    begin
                        cmd.srch_init = 1'b1;
                        st_next       = ST_SRCH;
                    end
                    else
                    begin
                        cmd.res_load  = 1'b1;
                        cmd.res_ok    = 1'b1;
                        cmd.use_limit = 1'b1;
                        st_next       = ST_OUT;
                    end
                end
            end
            ST_SRCH:
            begin
                if (sts.srch_done)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_ok   = 1'b1;
                    st_next      = ST_OUT;
                end
                else
                begin
                    cmd.round_start = 1'b1;
                    st_next         = ST_RND;
                end
            end
            ST_RND:
            begin
                if (!sts.round_busy)
                begin
                    cmd.round_done_take = 1'b1;
                    st_next             = ST_SRCH;
                end
            end
            ST_OUT:
            begin
                out_valid_next = 1'b1;
                st_next        = ST_LOAD;
            end
            default: st_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_LOAD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != ST_LOAD) |-> !in_ready)
        else $error("input taken while computing");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> out_valid_reg)
        else $error("result dropped");
    a_out_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(st_reg == ST_OUT))
        else $error("result raised outside output step");
endmodule

@@ design/kth_smallest_pair_sum.sv @@
`timescale 1ns / 1ps
// Channel  | Dir | Handshake             | Beat payload
// in       | in  | in_valid / in_ready   | value_a, value_b, last_item
// out      | out | out_valid / out_ready | kth_sum, found
// cfg      | in  | cfg_we (no wait)      | cfg_data -> k_rank
//
// Loading: one beat per cycle while in_ready is high, into two
// single-port-write RAMs. After the last beat: insertion sort of A then
// B through the RAM ports, then about 32 counting rounds, each a binary
// search in B per element of A, through the shared RAM read ports.
// Input is not taken during computing nor while a result waits.
// Reset: asynchronous, active low; k_rank returns to 1, count to zero.
module kth_smallest_pair_sum #(
    parameter int unsigned MAX_ELEMENTS = ksps_pkg::DEF_MAX_ELEMENTS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [ksps_pkg::VALUE_W-1:0] value_a,
    input  logic [ksps_pkg::VALUE_W-1:0] value_b,
    input  logic                         last_item,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [ksps_pkg::SUM_W-1:0]   kth_sum,
    output logic                         found,
    input  logic                         cfg_we,
    input  logic [ksps_pkg::RANK_W-1:0]  cfg_data
);
    import ksps_pkg::*;

    ksps_cmd_t          cmd;
    ksps_sts_t          sts;
    logic [RANK_W-1:0]  k_rank_reg;

    // rank register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_rank_reg <= RANK_W'(1);
        end
        else if (cfg_we)
        begin
            k_rank_reg <= cfg_data;
        end
    end

    ksps_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .last_item(last_item),
        .out_valid(out_valid), .out_ready(out_ready),
        .cmd(cmd), .sts(sts));

    ksps_datapath #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .value_a(value_a), .value_b(value_b), .k_rank(k_rank_reg),
        .res_sum(kth_sum), .res_found(found));
endmodule

@@ test/kth_smallest_pair_sum_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the k-th smallest pair sum block.
// Stimulus is queued by the sequencer (initial block), driven on falling
// edges and checked against a behavioural predictor on rising edges.
module kth_smallest_pair_sum_tb;
    import ksps_pkg::*;

    localparam int unsigned DEPTH      = DEF_MAX_ELEMENTS;
    localparam int unsigned LONG_HOLD  = 4000;
    localparam longint      CYCLE_CAP  = 40000000;
    localparam logic [RANK_W-1:0] RANK_MAX = '1;

    typedef struct {
        logic [VALUE_W-1:0] a;
        logic [VALUE_W-1:0] b;
        logic               last;
    } pair_beat_t;

    typedef struct {
        logic [SUM_W-1:0] kth_sum;
        logic             found;
    } kth_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [VALUE_W-1:0] value_a = '0;
    logic [VALUE_W-1:0] value_b = '0;
    logic               last_item = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [SUM_W-1:0]   kth_sum;
    logic               found;
    logic               cfg_we = 1'b0;
    logic [RANK_W-1:0]  cfg_data = '0;

    kth_smallest_pair_sum DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value_a   (value_a),
        .value_b   (value_b),
        .last_item (last_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kth_sum   (kth_sum),
        .found     (found),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    pair_beat_t  pending_beats[$];
    kth_result_t sums_due[$];

    // predictor state: held arrays, count and rank
    longint            held_a[DEPTH];
    longint            held_b[DEPTH];
    longint            sorted_a[];
    longint            sorted_b[];
    int unsigned       held_count = 0;
    logic [RANK_W-1:0] rank_k = 1;

    int  errors = 0;
    int  beats_in = 0;
    int  sums_out = 0;
    int  missing_sets = 0;
    bit  no_gaps = 1'b0;       // burst mode: neither side idles
    bit  long_hold_req = 1'b0; // ask receiver for one long stall
    bit  long_hold_done = 1'b0;
    bit  in_took = 1'b0;
    bit  out_took = 1'b0;
    int  tx_wait = 0;
    int  rx_wait = 0;
    int  hold_left = 0;
    longint cycles = 0;

    // pairs (i,j) with sorted_a[i] + sorted_b[j] <= x
    function automatic longint pairs_le(longint x, int n);
        longint total;
        int lo;
        int hi;
        int mid;
        total = 0;
        for (int i = 0; i < n; i++) begin
            if (sorted_a[i] <= x) begin
                lo = 0;
                hi = n;
                while (lo < hi) begin
                    mid = lo + (hi - lo) / 2;
                    if (sorted_b[mid] <= x - sorted_a[i]) lo = mid + 1;
                    else hi = mid;
                end
                total += lo;
            end
        end
        return total;
    endfunction

    // one accepted beat; a last beat queues the expected answer
    task automatic predict_beat(logic [VALUE_W-1:0] a, logic [VALUE_W-1:0] b,
                                logic last);
        kth_result_t r;
        int n;
        longint lo;
        longint hi;
        longint mid;
        if (held_count < DEPTH) begin
            held_a[held_count] = a;
            held_b[held_count] = b;
            held_count++;
        end
        if (!last) return;
        n = held_count;
        held_count = 0;
        if (longint'(rank_k) > longint'(n) * n) begin
            r.kth_sum = '0;
            r.found   = 1'b0;
        end else begin
            sorted_a = new[n];
            sorted_b = new[n];
            for (int i = 0; i < n; i++) begin
                sorted_a[i] = held_a[i];
                sorted_b[i] = held_b[i];
            end
            sorted_a.sort();
            sorted_b.sort();
            lo = 0;
            hi = SUM_LIMIT;
            // saturate when even the top of the range holds too few pairs
            if (pairs_le(SUM_LIMIT, n) >= rank_k) begin
                while (lo < hi) begin
                    mid = lo + (hi - lo) / 2;
                    if (pairs_le(mid, n) >= rank_k) hi = mid;
                    else lo = mid + 1;
                end
            end else begin
                lo = SUM_LIMIT;
            end
            r.kth_sum = lo[SUM_W-1:0];
            r.found   = 1'b1;
        end
        sums_due.push_back(r);
    endtask

    // rising edge: handshakes, prediction, checking, watchdog
    always @(posedge clk) begin
        kth_result_t e;
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("%0t: timeout, %0d sums still due", $time, sums_due.size());
            $display("FAILURE");
            $finish;
        end
        in_took  <= rst_n && in_valid && in_ready;
        out_took <= rst_n && out_valid && out_ready;
        if (rst_n && in_valid && in_ready) begin
            beats_in++;
            predict_beat(value_a, value_b, last_item);
        end
        if (rst_n && out_valid && out_ready) begin
            sums_out++;
            if (sums_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat kth_sum=%0d found=%0b",
                         $time, kth_sum, found);
            end else begin
                e = sums_due.pop_front();
                if (kth_sum !== e.kth_sum) begin
                    errors++;
                    $display("%0t: kth_sum expected %0d got %0d",
                             $time, e.kth_sum, kth_sum);
                end
                if (found !== e.found) begin
                    errors++;
                    $display("%0t: found expected %0b got %0b",
                             $time, e.found, found);
                end
            end
        end
    end

    // sender: valid held with payload until taken, random gap per beat
    always @(negedge clk) begin
        pair_beat_t it;
        if (rst_n && (!in_valid || in_took)) begin
            if (tx_wait > 0) begin
                tx_wait--;
                in_valid <= 1'b0;
            end else if (pending_beats.size() > 0) begin
                it = pending_beats.pop_front();
                in_valid  <= 1'b1;
                value_a   <= it.a;
                value_b   <= it.b;
                last_item <= it.last;
                tx_wait = no_gaps ? 0 : $urandom_range(0, 17);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stall per beat, plus one long hold-off on request
    always @(negedge clk) begin
        if (rst_n) begin
            if (long_hold_req && !long_hold_done) begin
                hold_left = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            if (out_took) rx_wait = no_gaps ? 0 : $urandom_range(0, 17);
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    function automatic logic [VALUE_W-1:0] draw_value(int spread);
        case (spread)
            0:       return VALUE_W'($urandom);
            1:       return VALUE_W'($urandom_range(0, 999999999));
            default: return VALUE_W'($urandom_range(0, 15));  // plenty of ties
        endcase
    endfunction

    task automatic queue_set(int n, int spread);
        pair_beat_t it;
        for (int i = 0; i < n; i++) begin
            it.a    = draw_value(spread);
            it.b    = draw_value(spread);
            it.last = (i == n - 1);
            pending_beats.push_back(it);
        end
        missing_sets++;
    endtask

    task automatic queue_pair(logic [VALUE_W-1:0] a, logic [VALUE_W-1:0] b,
                              logic last);
        pair_beat_t it;
        it.a    = a;
        it.b    = b;
        it.last = last;
        pending_beats.push_back(it);
    endtask

    // block idle: nothing queued, nothing in flight, nothing due
    task automatic drain();
        while (pending_beats.size() > 0 || in_valid || sums_due.size() > 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic set_rank(logic [RANK_W-1:0] k);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= k;
        rank_k = k;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    logic [RANK_W-1:0] phase_rank[8] = '{1, 5, 17, 0, 60, 144, 3, 2};

    initial begin
        int n;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // --- directed: reset rank of 1 ---
        queue_pair('0, '0, 1'b1);                   // single zero pair
        queue_pair('1, '1, 1'b1);                   // sum beyond range: saturates
        queue_pair(999999999, 999999999, 1'b0);     // top of legal range
        queue_pair(0, 1, 1'b1);
        queue_pair(7, 3, 1'b0);
        queue_pair(3, 7, 1'b0);
        queue_pair(5, 5, 1'b1);                     // tie of sums
        drain();

        set_rank('0);                               // rank zero: 0, found
        queue_pair(12, 34, 1'b0);
        queue_pair(56, 78, 1'b1);
        drain();

        set_rank(RANK_MAX);                         // rank beyond any n*n
        queue_pair('1, '0, 1'b1);
        queue_pair(100, 200, 1'b0);
        queue_pair(300, 400, 1'b1);
        drain();

        set_rank(4);                                // k exactly n*n
        queue_pair(1, 2, 1'b0);
        queue_pair('1, 999999999, 1'b1);
        drain();

        // full store, rank n*n at depth; extra beats dropped, last one dropped
        set_rank(21'd1048576);
        for (int i = 0; i < DEPTH + 6; i++)
            queue_pair(VALUE_W'(i * 3), VALUE_W'(i * 5), i == DEPTH + 5);
        drain();

        // --- random phases ---
        for (int ph = 0; ph < 8; ph++) begin
            set_rank(phase_rank[ph]);
            no_gaps = (ph == 2);
            if (ph == 4) long_hold_req = 1'b1;      // receiver stalls, input backs up
            for (int s = 0; s < 17; s++) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 32)
                                                : $urandom_range(1, 8);
                queue_set(n, $urandom_range(0, 2));
                // sender pause: hold back until everything has come out
                if (ph == 5 && s == 8) begin
                    while (pending_beats.size() > 0 || in_valid || sums_due.size() > 0)
                        @(negedge clk);
                end
            end
            drain();
        end
        no_gaps = 1'b0;

        repeat (50) @(negedge clk);
        $display("Covered %0d beats and %0d sums over 13 rank settings,", beats_in, sums_out);
        $display("including a full store, saturation and an out-of-range rank.");
        if (errors == 0 && sums_due.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
design/ksps_pkg.sv
design/ksps_ram.sv
design/ksps_datapath.sv
design/ksps_ctrl.sv
design/kth_smallest_pair_sum.sv
test/kth_smallest_pair_sum_tb.sv
